@@ hdl/wsdf_pkg.sv @@
// Package for the WebSocket frame deframer: transfer types, phase and code constants.
package wsdf_pkg;

    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_KEY    = 3'd3,
        PH_DATA   = 3'd4,
        PH_CLOSED = 3'd5
    } phase_t;

    localparam logic [3:0] OPC_CONT  = 4'h0;
    localparam logic [3:0] OPC_TEXT  = 4'h1;
    localparam logic [3:0] OPC_BIN   = 4'h2;
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [3:0] OPC_PING  = 4'h9;

    localparam logic [6:0] LEN_INLINE_MAX = 7'd125;
    localparam logic [6:0] LEN_EXT16      = 7'd126;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_CLOSED = 2'd2;

    localparam logic [2:0] CAUSE_CONT  = 3'd0;
    localparam logic [2:0] CAUSE_BIN   = 3'd1;
    localparam logic [2:0] CAUSE_CLOSE = 3'd2;
    localparam logic [2:0] CAUSE_OTHER = 3'd3;
    localparam logic [2:0] CAUSE_ABORT = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       abort;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       is_ping;
        logic [2:0] close_cause;
    } result_t;

endpackage

@@ hdl/websocket_frame_deframer.sv @@
// Top level of the WebSocket frame deframer: header parse, unmasking and output buffering.
//
// Usage: received stream bytes arrive on the item channel (item_valid, item_stall, item),
// one byte per transfer. Each byte gives at most one result on the result channel
// (result_valid, result_stall, result): an unmasked payload byte, an empty-message marker
// or a channel-closed notice with its cause.
// A result is registered: built from the transferred byte, it enters the result register
// (or the skid register while the receiver stalls). Throughput: one byte per cycle while
// item_stall is low; the whole per-byte step (phase decode, 64-bit length count, key select
// and XOR) sits between the byte transfer and the result register.
// Stall: the result register is backed by a one-entry skid register, so a byte is still
// taken in the cycle the receiver first stalls. item_stall rises only while the skid
// register holds a result, and falls as soon as the receiver takes a transfer.
// Reset: rst_n clears the phase to the first header byte, zeroes the frame state and
// empties both result registers. After a close the block takes and drops every byte
// until the next reset.
module websocket_frame_deframer
    import wsdf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // Frame state
    phase_t      phase_reg,   phase_next;
    logic [3:0]  opcode_reg,  opcode_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [63:0] remaining_reg, remaining_next;
    logic [31:0] key_reg,     key_next;
    logic [1:0]  key_idx_reg, key_idx_next;

    // Output buffering
    result_t     result_reg;
    logic        result_valid_reg;
    result_t     skid_reg;
    logic        skid_valid_reg;

    // Result produced by the byte in flight this cycle
    logic        gen_valid;
    result_t     gen;

    logic        item_take;
    logic        result_take;
    logic        ping;
    logic [6:0]  len7;
    logic [1:0]  key_idx_inc;
    logic [63:0] remaining_dec;
    logic [7:0]  key_byte;

    assign item_stall   = skid_valid_reg;
    assign item_take    = item_valid & ~skid_valid_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign result_take  = result_valid_reg & ~result_stall;

    assign ping          = (opcode_reg == OPC_PING);
    assign len7          = item.rx_byte[6:0];
    assign key_idx_inc   = key_idx_reg + 2'd1;
    assign remaining_dec = (remaining_reg != 64'd0) ? (remaining_reg - 64'd1) : 64'd0;

    always_comb
    begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Per-byte step: next frame state and the result, if any
    always_comb
    begin
        phase_next     = phase_reg;
        opcode_next    = opcode_reg;
        ext_left_next  = ext_left_reg;
        remaining_next = remaining_reg;
        key_next       = key_reg;
        key_idx_next   = key_idx_reg;
        gen_valid      = 1'b0;
        gen            = '0;

        if (item_take && phase_reg != PH_CLOSED && phase_reg inside {PH_HDR0, PH_HDR1,
                PH_EXTLEN, PH_KEY, PH_DATA})
        begin
            if (item.abort)
            begin
                phase_next       = PH_CLOSED;
                gen_valid        = 1'b1;
                gen.kind         = KIND_CLOSED;
                gen.close_cause  = CAUSE_ABORT;
            end
            else
            begin
                case (phase_reg)
                    PH_HDR0:
                    begin
                        opcode_next = item.rx_byte[3:0];
                        phase_next  = PH_HDR1;
                    end
                    PH_HDR1:
                    begin
                        if (opcode_reg == OPC_TEXT || opcode_reg == OPC_PING)
                        begin
                            key_next     = '0;
                            key_idx_next = '0;
                            if (len7 <= LEN_INLINE_MAX)
                            begin
                                remaining_next = {57'd0, len7};
                                ext_left_next  = '0;
                                phase_next     = PH_KEY;
                            end
                            else
                            begin
                                remaining_next = '0;
                                ext_left_next  = (len7 == LEN_EXT16) ? EXT16_BYTES
                                                                     : EXT64_BYTES;
                                phase_next     = PH_EXTLEN;
                            end
                        end
                        else
                        begin
                            // Reject the frame: close with the opcode's cause
                            phase_next = PH_CLOSED;
                            gen_valid  = 1'b1;
                            gen.kind   = KIND_CLOSED;
                            case (opcode_reg)
                                OPC_CONT:  gen.close_cause = CAUSE_CONT;
                                OPC_BIN:   gen.close_cause = CAUSE_BIN;
                                OPC_CLOSE: gen.close_cause = CAUSE_CLOSE;
                                default:   gen.close_cause = CAUSE_OTHER;
                            endcase
                        end
                    end
                    PH_EXTLEN:
                    begin
                        remaining_next = {remaining_reg[55:0], item.rx_byte};
                        ext_left_next  = ext_left_reg - 4'd1;
                        if (ext_left_next == 4'd0)
                        begin
                            phase_next = PH_KEY;
                        end
                    end
                    PH_KEY:
                    begin
                        key_next     = {key_reg[23:0], item.rx_byte};
                        key_idx_next = key_idx_inc;
                        if (key_idx_inc == 2'd0)
                        begin
                            if (remaining_reg == 64'd0)
                            begin
                                phase_next  = PH_HDR0;
                                gen_valid   = 1'b1;
                                gen.kind    = KIND_EMPTY;
                                gen.last    = 1'b1;
                                gen.is_ping = ping;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                    end
                    default:
                    begin
                        // Payload byte: unmask and count down
                        key_idx_next   = key_idx_inc;
                        remaining_next = remaining_dec;
                        gen_valid      = 1'b1;
                        gen.kind       = KIND_BYTE;
                        gen.data       = item.rx_byte ^ key_byte;
                        gen.last       = (remaining_dec == 64'd0);
                        gen.is_ping    = ping;
                        if (remaining_dec == 64'd0)
                        begin
                            phase_next = PH_HDR0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            opcode_reg    <= '0;
            ext_left_reg  <= '0;
            remaining_reg <= '0;
            key_reg       <= '0;
            key_idx_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            opcode_reg    <= opcode_next;
            ext_left_reg  <= ext_left_next;
            remaining_reg <= remaining_next;
            key_reg       <= key_next;
            key_idx_reg   <= key_idx_next;
        end
    end

    // Output register and skid register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Drain the skid register first; no byte is taken meanwhile
            if (result_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!result_valid_reg || result_take)
        begin
            result_valid_reg <= gen_valid;
        end
        else if (gen_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid register: payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (result_take)
            begin
                result_reg <= skid_reg;
            end
        end
        else if (!result_valid_reg || result_take)
        begin
            result_reg <= gen;
        end
        else if (gen_valid)
        begin
            skid_reg <= gen;
        end
    end

`ifndef ASSERT_OFF
    // A held skid entry always sits behind a presented result
    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    // Nothing is produced once the channel is closed
    a_silent_when_closed: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CLOSED |-> !gen_valid)
        else $error("result produced after channel close");

    // A close result always leaves the block in the closed phase
    a_close_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (gen_valid && gen.kind == KIND_CLOSED) |=> phase_reg == PH_CLOSED)
        else $error("close result without entering the closed phase");

    // The final payload byte returns the parser to the first header byte
    a_last_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        (gen_valid && gen.kind == KIND_BYTE && gen.last) |=> phase_reg == PH_HDR0)
        else $error("last payload byte did not return to header parsing");
`endif

endmodule
